@@ rtl/lkvc_pkg.sv @@
`default_nettype none

package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CFG_W   = 5;
  localparam int IN_DATA_W  = KEY_W + VAL_W;
  localparam int OUT_DATA_W = VAL_W;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

endpackage

`default_nettype wire

@@ rtl/lkvc_ram.sv @@
`default_nettype none

module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                          wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ rtl/lru_key_value_cache_top.sv @@
`default_nettype none

// Channel | Ports          | Payload
// --------+----------------+-------------------------------------------
// input   | in_t*          | tuser: req_type; tdata: key, value
// result  | out_t*         | tuser: found; tdata: read_value
// config  | cfg_wr_*       | capacity (5 bits), written when cfg_wr_en
//
// A request is served by a scan of the key/value RAMs through one comparator,
// one entry per cycle, and then a commit state that registers the result.
// in_tready is high only while the sequencer is idle; the next request may
// transfer in the same cycle that the registered result is first presented.
// A held result (out_tready low) stalls the commit of the following request.
// Synchronous active-low reset clears valid bits, ranks, occupancy; capacity resets to 16.

module lru_key_value_cache_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [lkvc_pkg::IN_DATA_W-1:0]    in_tdata,   // key, value
  input  wire logic                              in_tuser,   // req_type
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [lkvc_pkg::OUT_DATA_W-1:0]   out_tdata,  // read_value
  output logic                                   out_tuser,  // found
  input  wire logic                              cfg_wr_en,
  input  wire logic [lkvc_pkg::CFG_W-1:0]        cfg_wr_data
);

  lkvc_pkg::state_t                 state_r, state_nxt;
  logic [lkvc_pkg::CFG_W-1:0]       cap_r;
  lkvc_pkg::cnt_t                   cnt_r, cnt_nxt;
  logic [lkvc_pkg::ENTRIES-1:0]     valid_r, valid_nxt;
  lkvc_pkg::idx_t                   rank_r   [lkvc_pkg::ENTRIES];
  lkvc_pkg::idx_t                   rank_nxt [lkvc_pkg::ENTRIES];

  logic                             put_r;
  logic [lkvc_pkg::KEY_W-1:0]       key_r;
  logic [lkvc_pkg::VAL_W-1:0]       val_r;

  lkvc_pkg::idx_t                   scan_idx_r, scan_idx_nxt;
  lkvc_pkg::idx_t                   cmp_idx_r;
  logic                             cmp_vld_r, cmp_vld_nxt;
  logic                             hit_r, hit_nxt;
  lkvc_pkg::idx_t                   hit_idx_r, hit_idx_nxt;
  lkvc_pkg::idx_t                   hit_rank_r, hit_rank_nxt;
  logic [lkvc_pkg::VAL_W-1:0]       hit_val_r, hit_val_nxt;
  lkvc_pkg::idx_t                   victim_r, victim_nxt;

  logic                             out_tvalid_r, out_tvalid_nxt;
  logic                             out_found_r, out_found_nxt;
  logic [lkvc_pkg::VAL_W-1:0]       out_rdval_r, out_rdval_nxt;

  logic [lkvc_pkg::KEY_W-1:0]       key_rd;
  logic [lkvc_pkg::VAL_W-1:0]       val_rd;
  logic                             key_we, val_we;
  lkvc_pkg::idx_t                   val_waddr;

  lkvc_pkg::cnt_t                   eff_cap;
  lkvc_pkg::cnt_t                   cnt_m1;
  logic                             in_xfer, out_free, cmp_live, match, oldest;
  logic                             do_evict, do_insert;
  logic [lkvc_pkg::ENTRIES-1:0]     valid_ev;
  lkvc_pkg::idx_t                   slot;
  localparam lkvc_pkg::idx_t        LAST_IDX = lkvc_pkg::IDX_W'(lkvc_pkg::ENTRIES - 1);

  assign in_tready  = (state_r == lkvc_pkg::ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = out_rdval_r;

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = lkvc_pkg::CNT_W'(1);
    end else if (int'(cap_r) > lkvc_pkg::ENTRIES) begin
      eff_cap = lkvc_pkg::CNT_W'(lkvc_pkg::ENTRIES);
    end else begin
      eff_cap = lkvc_pkg::CNT_W'(cap_r);
    end
  end

  assign cnt_m1   = cnt_r - lkvc_pkg::CNT_W'(1);
  assign cmp_live = cmp_vld_r && valid_r[cmp_idx_r];
  assign match    = cmp_live && (key_rd == key_r);
  assign oldest   = cmp_live && (lkvc_pkg::CNT_W'(rank_r[cmp_idx_r]) == cnt_m1);

  assign do_evict  = !hit_r && (put_r == lkvc_pkg::REQ_PUT) && (cnt_r >= eff_cap);
  assign do_insert = !hit_r && (put_r == lkvc_pkg::REQ_PUT);

  always_comb begin
    valid_ev = valid_r;
    if (do_evict) begin
      valid_ev[victim_r] = 1'b0;
    end
  end

  always_comb begin
    slot = '0;
    for (int i = lkvc_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (!valid_ev[i]) begin
        slot = lkvc_pkg::IDX_W'(i);
      end
    end
  end

  assign key_we    = (state_r == lkvc_pkg::ST_UPD) && out_free && do_insert;
  assign val_we    = (state_r == lkvc_pkg::ST_UPD) && out_free && (put_r == lkvc_pkg::REQ_PUT);
  assign val_waddr = hit_r ? hit_idx_r : slot;

  always_comb begin
    state_nxt      = state_r;
    scan_idx_nxt   = scan_idx_r;
    cmp_vld_nxt    = cmp_vld_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_rank_nxt   = hit_rank_r;
    hit_val_nxt    = hit_val_r;
    victim_nxt     = victim_r;
    cnt_nxt        = cnt_r;
    valid_nxt      = valid_r;
    rank_nxt       = rank_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_found_nxt  = out_found_r;
    out_rdval_nxt  = out_rdval_r;

    unique case (state_r)
      lkvc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_nxt    = lkvc_pkg::ST_SCAN;
          scan_idx_nxt = '0;
          cmp_vld_nxt  = 1'b0;
          hit_nxt      = 1'b0;
        end
      end
      lkvc_pkg::ST_SCAN: begin
        cmp_vld_nxt = 1'b1;
        if (scan_idx_r != LAST_IDX) begin
          scan_idx_nxt = scan_idx_r + lkvc_pkg::IDX_W'(1);
        end
        if (match && !hit_r) begin
          hit_nxt      = 1'b1;
          hit_idx_nxt  = cmp_idx_r;
          hit_rank_nxt = rank_r[cmp_idx_r];
          hit_val_nxt  = val_rd;
        end
        if (oldest) begin
          victim_nxt = cmp_idx_r;
        end
        if (cmp_vld_r && (cmp_idx_r == LAST_IDX)) begin
          state_nxt = lkvc_pkg::ST_UPD;
        end
      end
      lkvc_pkg::ST_UPD: begin
        if (out_free) begin
          state_nxt      = lkvc_pkg::ST_IDLE;
          out_tvalid_nxt = 1'b1;
          out_found_nxt  = hit_r;
          out_rdval_nxt  = (hit_r && (put_r == lkvc_pkg::REQ_GET)) ? hit_val_r : '0;
          if (hit_r) begin
            for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
              if (valid_r[i] && (rank_r[i] < hit_rank_r)) begin
                rank_nxt[i] = rank_r[i] + lkvc_pkg::IDX_W'(1);
              end
            end
            rank_nxt[hit_idx_r] = '0;
          end else if (do_insert) begin
            for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
              if (valid_ev[i]) begin
                rank_nxt[i] = rank_r[i] + lkvc_pkg::IDX_W'(1);
              end
            end
            if (do_evict) begin
              rank_nxt[victim_r] = '0;
            end
            rank_nxt[slot] = '0;
            valid_nxt       = valid_ev;
            valid_nxt[slot] = 1'b1;
            cnt_nxt = do_evict ? cnt_r : cnt_r + lkvc_pkg::CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = lkvc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lkvc_pkg::ST_IDLE;
      cap_r        <= lkvc_pkg::CAP_RESET;
      cnt_r        <= '0;
      valid_r      <= '0;
      cmp_vld_r    <= 1'b0;
      hit_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      valid_r      <= valid_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      hit_r        <= hit_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      rank_r       <= rank_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      put_r <= in_tuser;
      key_r <= in_tdata[lkvc_pkg::KEY_W-1:0];
      val_r <= in_tdata[lkvc_pkg::IN_DATA_W-1:lkvc_pkg::KEY_W];
    end
    scan_idx_r  <= scan_idx_nxt;
    cmp_idx_r   <= scan_idx_r;
    hit_idx_r   <= hit_idx_nxt;
    hit_rank_r  <= hit_rank_nxt;
    hit_val_r   <= hit_val_nxt;
    victim_r    <= victim_nxt;
    out_found_r <= out_found_nxt;
    out_rdval_r <= out_rdval_nxt;
  end

  lkvc_ram #(
    .WIDTH (lkvc_pkg::KEY_W),
    .DEPTH (lkvc_pkg::ENTRIES)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (key_we),
    .wr_addr (slot),
    .wr_data (key_r),
    .rd_addr (scan_idx_r),
    .rd_data (key_rd)
  );

  lkvc_ram #(
    .WIDTH (lkvc_pkg::VAL_W),
    .DEPTH (lkvc_pkg::ENTRIES)
  ) u_val_ram (
    .clk     (clk),
    .wr_en   (val_we),
    .wr_addr (val_waddr),
    .wr_data (val_r),
    .rd_addr (scan_idx_r),
    .rd_data (val_rd)
  );

  a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(cnt_r))
    else $error("occupancy count disagrees with valid bits");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= lkvc_pkg::ENTRIES)
    else $error("occupancy above entry count");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_found_r) |-> (out_rdval_r == '0))
    else $error("miss result carries nonzero value");

  a_commit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lkvc_pkg::ST_UPD && out_free) |=> (state_r == lkvc_pkg::ST_IDLE && out_tvalid_r))
    else $error("commit did not present a result");

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import lkvc_pkg::*;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] rd_value;
  } reply_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // key, value
  logic                  in_tuser = 1'b0; // req_type
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // read_value
  logic                  out_tuser;       // found
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]      cfg_wr_data = CAP_RESET;

  // cache shadow
  logic [KEY_W-1:0] cache_keys [ENTRIES];
  logic [VAL_W-1:0] cache_vals [ENTRIES];
  logic             cache_live [ENTRIES];
  idx_t             cache_age  [ENTRIES];
  cnt_t             cache_fill;
  logic [CFG_W-1:0] cache_cap;

  req_t        req_backlog [$];
  reply_t      lookup_replies [$];
  int unsigned fail_count = 0;
  int          in_hold = 0;
  int          out_hold = 0;
  bit          no_idle = 1'b0;

  lru_key_value_cache_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      cache_live[i] = 1'b0;
      cache_age[i]  = '0;
    end
    cache_fill = '0;
    cache_cap  = CAP_RESET;
  end

  function automatic reply_t serve_request(logic kind, logic [KEY_W-1:0] key,
                                           logic [VAL_W-1:0] value);
    reply_t r;
    int     hit;
    int     oldest;
    int     slot;
    int     eff;
    idx_t   a;
    r   = '0;
    hit = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && cache_live[i] && cache_keys[i] == key) hit = i;
    end
    if (hit >= 0) begin
      r.found = 1'b1;
      a = cache_age[hit];
      for (int i = 0; i < ENTRIES; i++) begin
        if (cache_live[i] && cache_age[i] < a) cache_age[i]++;
      end
      cache_age[hit] = '0;
      if (kind == REQ_PUT) cache_vals[hit] = value;
      else r.rd_value = cache_vals[hit];
    end else if (kind == REQ_PUT) begin
      eff = (cache_cap == 0) ? 1 : (cache_cap > ENTRIES) ? ENTRIES : int'(cache_cap);
      if (int'(cache_fill) >= eff) begin
        oldest = -1;
        for (int i = 0; i < ENTRIES; i++) begin
          if (cache_live[i] && (oldest < 0 || cache_age[i] > cache_age[oldest])) oldest = i;
        end
        if (oldest >= 0) begin
          cache_live[oldest] = 1'b0;
          cache_age[oldest]  = '0;
          if (cache_fill > 0) cache_fill--;
        end
      end
      slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot < 0 && !cache_live[i]) slot = i;
      end
      if (slot >= 0) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (cache_live[i]) cache_age[i]++;
        end
        cache_keys[slot] = key;
        cache_vals[slot] = value;
        cache_live[slot] = 1'b1;
        cache_age[slot]  = '0;
        cache_fill++;
      end
    end
    return r;
  endfunction

  // request driver; prediction is taken at each input transfer
  always @(posedge clk) begin : drive_req
    req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_hold   <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        lookup_replies.push_back(serve_request(in_tuser, in_tdata[KEY_W-1:0],
                                               in_tdata[IN_DATA_W-1:KEY_W]));
      end
      if (!in_tvalid || in_tready) begin
        if (in_hold != 0) begin
          in_hold   <= in_hold - 1;
          in_tvalid <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 5) == 0) begin
          in_hold   <= $urandom_range(0, 10);
          in_tvalid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          nxt = req_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= nxt.kind;
          in_tdata  <= {nxt.value, nxt.key};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_reply
    reply_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_hold   <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (lookup_replies.size() == 0) begin
          $error("result with nothing pending: found=%0b read_value=%h", out_tuser, out_tdata);
          fail_count++;
        end else begin
          want = lookup_replies.pop_front();
          if (out_tuser !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, out_tuser);
            fail_count++;
          end
          if (out_tdata !== want.rd_value) begin
            $error("read_value: expected %h, got %h", want.rd_value, out_tdata);
            fail_count++;
          end
        end
      end
      if (out_hold != 0) begin
        out_hold   <= out_hold - 1;
        out_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_hold   <= $urandom_range(0, 10);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic queue_req(logic kind, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
    req_t r;
    r.kind  = kind;
    r.key   = key;
    r.value = value;
    req_backlog.push_back(r);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (req_backlog.size() != 0 || in_tvalid || lookup_replies.size() != 0);
  endtask

  task automatic set_capacity(logic [CFG_W-1:0] cap);
    wait_drained();
    repeat (2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cache_cap = cap;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // mixed gets/puts over a small key pool so hits and evictions both happen
  task automatic random_burst(int n, int pool_n);
    logic [KEY_W-1:0] pool [$];
    logic [KEY_W-1:0] k;
    for (int i = 0; i < pool_n; i++) pool.push_back(pick_word());
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) k = $urandom;
      else k = pool[$urandom_range(0, pool_n - 1)];
      queue_req($urandom_range(0, 1) ? REQ_PUT : REQ_GET, k, pick_word());
    end
  endtask

  initial begin : stimulus
    int c;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    set_capacity(5'd16);
    queue_req(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    queue_req(REQ_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_req(REQ_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_req(REQ_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_req(REQ_PUT, 32'h0000_0000, 32'h0000_0000);
    queue_req(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);  // stored -1 is a hit
    queue_req(REQ_GET, 32'h8000_0000, 32'h0000_0000);
    queue_req(REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    queue_req(REQ_PUT, 32'h8000_0000, 32'h1234_5678);  // update in place
    queue_req(REQ_GET, 32'h8000_0000, 32'h0000_0000);
    queue_req(REQ_GET, 32'h0000_0001, 32'h0000_0000);
    queue_req(REQ_GET, 32'h0000_0000, 32'hFFFF_FFFF);  // get ignores value

    // capacity dropped below occupancy: one eviction per missing put
    set_capacity(5'd2);
    queue_req(REQ_GET, 32'h0000_0000, 32'h0000_0000);
    queue_req(REQ_PUT, 32'h0000_0055, 32'hA5A5_A5A5);
    queue_req(REQ_PUT, 32'h0000_0066, 32'h5A5A_5A5A);
    queue_req(REQ_PUT, 32'h0000_0077, 32'h0000_0001);
    queue_req(REQ_GET, 32'h8000_0000, 32'h0000_0000);
    queue_req(REQ_GET, 32'h0000_0077, 32'h0000_0000);
    queue_req(REQ_PUT, 32'h0000_0077, 32'hFFFF_FFFF);
    queue_req(REQ_GET, 32'h0000_0077, 32'h0000_0000);
    queue_req(REQ_GET, 32'h0000_0000, 32'h0000_0000);

    set_capacity(5'd0);
    random_burst(100, 3);
    set_capacity(5'd31);
    random_burst(160, 24);
    set_capacity(5'd1);
    random_burst(60, 3);
    c = $urandom_range(2, 15);
    set_capacity(c[CFG_W-1:0]);
    random_burst(160, c + 4);
    c = $urandom_range(17, 30);
    set_capacity(c[CFG_W-1:0]);
    random_burst(110, 22);
    set_capacity(5'd8);
    random_burst(130, 11);

    wait_drained();
    no_idle = 1'b1;
    set_capacity(5'd16);
    random_burst(200, 20);

    wait_drained();
    repeat (25) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
